// ===== hw/rtl/blsph_pkg.sv =====
package blsph_pkg;

  // block sizing
  localparam int BAND_CNT   = 16;
  localparam int BAR_HEIGHT = 16;
  localparam int BAND_W     = (BAND_CNT > 1) ? $clog2(BAND_CNT) : 1;

  // field widths
  localparam int LEVEL_W = 12;
  localparam int PEAK_W  = 5;
  localparam int RAW_W   = 24;
  localparam int BIDX_W  = 4;
  localparam int DIV_W   = 16;
  localparam int PCT_W   = 7;
  localparam int SUM_W   = LEVEL_W + PCT_W + 1;
  localparam int CNT_W   = $clog2(RAW_W + 1);

  // caps
  localparam int LEVEL_MAX    = (1 << LEVEL_W) - 1;
  localparam int PEAK_MAX     = (1 << PEAK_W) - 1;
  localparam int FINE_CAP_RAW = 255 * BAR_HEIGHT;
  localparam int FINE_CAP     = (FINE_CAP_RAW > LEVEL_MAX) ? LEVEL_MAX : FINE_CAP_RAW;
  localparam int BAR_CAP      = (BAR_HEIGHT > LEVEL_MAX) ? LEVEL_MAX : BAR_HEIGHT;
  localparam int PEAK_CAP     = (BAR_HEIGHT > PEAK_MAX) ? PEAK_MAX : BAR_HEIGHT;
  localparam int PCT_FULL     = 100;

  // x / 100 as (x * 335545) >> 25, exact for every weighted sum up to 100 * 4095
  localparam int                 RECIP_W     = 19;
  localparam int                 RECIP_SHIFT = 25;
  localparam int                 PROD_W      = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] PCT_RECIP   = 19'd335545;

  // APB register file
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [1:0] REG_FINE_MODE = 2'd0;
  localparam logic [1:0] REG_BAR_DIV   = 2'd1;
  localparam logic [1:0] REG_FINE_DIV  = 2'd2;
  localparam logic [1:0] REG_SMOOTH    = 2'd3;

  // item commands
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_DECAY  = 1'b1;

  typedef struct packed {
    logic               fine_mode;
    logic [DIV_W-1:0]   bar_divisor;
    logic [DIV_W-1:0]   fine_divisor;
    logic [PCT_W-1:0]   smoothing_percent;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic [RAW_W-1:0]   dividend;
    logic [DIV_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [RAW_W-1:0]   quotient;
  } div_rsp_t;

endpackage

// ===== hw/rtl/band_level_smoother_peak_hold.sv =====
// Spectrum bar conditioner with peak hold.
// Input channel (in_valid/in_ready): one transfer is a band sample
// (in_cmd = 0, in_band_index, in_raw_level) or a peak decay tick (in_cmd = 1).
// Output channel (out_valid/out_ready): exactly one result per input item, in
// order: the band's new smoothed level and peak, or decay_done for a tick.
// Configuration over a 32-bit APB-style port, registers at 0x0, 0x4, 0x8, 0xC;
// write only while the block is idle.
// Timing: one item at a time; in_ready is low while an item is in progress.
// A sample runs the serial divider once (level / divisor, one quotient
// bit a cycle, 24 bits); the /100 of the weighted sum is a reciprocal multiply.
// A zero divisor skips the divide. A decay tick walks the peak store one
// band a cycle.
// The result sits in an output register, so the next item may be taken while
// it waits; if the receiver stalls, the following item holds in its final
// state until the register frees up.
// Reset (rst_n, synchronous) restores register defaults and marks every band's
// level and peak as zero through per-band valid bits.
module band_level_smoother_peak_hold (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic [blsph_pkg::BIDX_W-1:0]  in_band_index,
  input  logic [blsph_pkg::RAW_W-1:0]   in_raw_level,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [blsph_pkg::LEVEL_W-1:0] out_smoothed_level,
  output logic [blsph_pkg::PEAK_W-1:0]  out_peak_level,
  output logic                          out_decay_done,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [blsph_pkg::ADDR_W-1:0]  paddr,
  input  logic [blsph_pkg::DATA_W-1:0]  pwdata,
  output logic [blsph_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);
  import blsph_pkg::*;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DGO1  = 4'd1; // start level / divisor
  localparam logic [3:0] S_DW1   = 4'd2;
  localparam logic [3:0] S_MIX   = 4'd3; // weighted sum
  localparam logic [3:0] S_SCALE = 4'd4; // sum / 100 by reciprocal
  localparam logic [3:0] S_UPD   = 4'd6; // store write-back
  localparam logic [3:0] S_DECAY = 4'd7; // peak walk
  localparam logic [3:0] S_EMIT  = 4'd8; // hand to output register

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [3:0]         state_r, state_nxt;
  logic [BAND_W-1:0]  idx_r, idx_nxt;
  logic [RAW_W-1:0]   raw_r, raw_nxt;
  logic [LEVEL_W-1:0] lvl_r, lvl_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [LEVEL_W-1:0] sm_r, sm_nxt;
  logic [PEAK_W-1:0]  pk_r, pk_nxt;
  logic               dk_r, dk_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0] out_sm_r, out_sm_nxt;
  logic [PEAK_W-1:0]  out_pk_r, out_pk_nxt;
  logic               out_dk_r, out_dk_nxt;

  // band stores, with valid bits standing in for the reset value
  logic [LEVEL_W-1:0] prev_r [BAND_CNT];
  logic [PEAK_W-1:0]  peak_r [BAND_CNT];
  logic [BAND_CNT-1:0] prev_vld_r, prev_vld_nxt;
  logic [BAND_CNT-1:0] peak_vld_r, peak_vld_nxt;
  logic               prev_we, peak_we;
  logic [LEVEL_W-1:0] prev_wd;
  logic [PEAK_W-1:0]  peak_wd;

  logic [LEVEL_W-1:0] prev_rd;
  logic [PEAK_W-1:0]  peak_rd;
  logic [LEVEL_W-1:0] cap;
  logic [DIV_W-1:0]   mode_div;
  logic [PCT_W-1:0]   pct;
  logic [PCT_W-1:0]   pct_old;
  logic               in_fire;
  logic               out_free;
  logic [PEAK_W-1:0]  pk_upd;
  logic [PROD_W-1:0]  sum_prod;

  blsph_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  blsph_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign prev_rd  = prev_vld_r[idx_r] ? prev_r[idx_r] : '0;
  assign peak_rd  = peak_vld_r[idx_r] ? peak_r[idx_r] : '0;
  assign cap      = cfg.fine_mode ? LEVEL_W'(FINE_CAP) : LEVEL_W'(BAR_CAP);
  assign mode_div = cfg.fine_mode ? cfg.fine_divisor : cfg.bar_divisor;
  assign pct      = (cfg.smoothing_percent > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL)
                                                              : cfg.smoothing_percent;
  assign pct_old  = PCT_W'(PCT_FULL) - pct;

  // sum never exceeds 100 * 4095, so the quotient fits the level without a clamp
  assign sum_prod = PROD_W'(sum_r) * PROD_W'(PCT_RECIP);

  // peak only rises in bar mode, capped at the bar height
  always_comb begin
    pk_upd = peak_rd;
    if (!cfg.fine_mode && (sm_r > LEVEL_W'(peak_rd))) begin
      pk_upd = (sm_r > LEVEL_W'(PEAK_CAP)) ? PEAK_W'(PEAK_CAP) : sm_r[PEAK_W-1:0];
    end
  end

  // divider request: level / mode divisor
  always_comb begin
    div_req.start    = (state_r == S_DGO1) && (mode_div != '0);
    div_req.dividend = raw_r;
    div_req.divisor  = mode_div;
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    raw_nxt       = raw_r;
    lvl_nxt       = lvl_r;
    sum_nxt       = sum_r;
    sm_nxt        = sm_r;
    pk_nxt        = pk_r;
    dk_nxt        = dk_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_sm_nxt    = out_sm_r;
    out_pk_nxt    = out_pk_r;
    out_dk_nxt    = out_dk_r;
    prev_we       = 1'b0;
    peak_we       = 1'b0;
    prev_wd       = sm_r;
    peak_wd       = pk_upd;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          raw_nxt = in_raw_level;
          sm_nxt  = '0;
          pk_nxt  = '0;
          dk_nxt  = 1'b0;
          if (in_cmd == CMD_DECAY) begin
            idx_nxt   = '0;
            dk_nxt    = 1'b1;
            state_nxt = S_DECAY;
          end else if (32'(in_band_index) >= BAND_CNT) begin
            state_nxt = S_EMIT;
          end else begin
            idx_nxt   = BAND_W'(in_band_index);
            state_nxt = S_DGO1;
          end
        end
      end
      S_DGO1: begin
        if (mode_div == '0) begin
          lvl_nxt   = cap;
          state_nxt = S_MIX;
        end else begin
          state_nxt = S_DW1;
        end
      end
      S_DW1: begin
        if (div_rsp.done) begin
          lvl_nxt   = (div_rsp.quotient > RAW_W'(cap)) ? cap
                                                       : div_rsp.quotient[LEVEL_W-1:0];
          state_nxt = S_MIX;
        end
      end
      S_MIX: begin
        sum_nxt   = SUM_W'(prev_rd) * SUM_W'(pct_old) + SUM_W'(lvl_r) * SUM_W'(pct);
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        sm_nxt    = sum_prod[RECIP_SHIFT +: LEVEL_W];
        state_nxt = S_UPD;
      end
      S_UPD: begin
        prev_we   = 1'b1;
        peak_we   = 1'b1;
        pk_nxt    = pk_upd;
        state_nxt = S_EMIT;
      end
      S_DECAY: begin
        if (peak_rd != '0) begin
          peak_we = 1'b1;
          peak_wd = peak_rd - 1'b1;
        end
        if (32'(idx_r) == BAND_CNT - 1) begin
          state_nxt = S_EMIT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_sm_nxt    = sm_r;
          out_pk_nxt    = pk_r;
          out_dk_nxt    = dk_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    prev_vld_nxt = prev_vld_r;
    peak_vld_nxt = peak_vld_r;
    if (prev_we) begin
      prev_vld_nxt[idx_r] = 1'b1;
    end
    if (peak_we) begin
      peak_vld_nxt[idx_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      prev_vld_r  <= '0;
      peak_vld_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      prev_vld_r  <= prev_vld_nxt;
      peak_vld_r  <= peak_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    raw_r    <= raw_nxt;
    lvl_r    <= lvl_nxt;
    sum_r    <= sum_nxt;
    sm_r     <= sm_nxt;
    pk_r     <= pk_nxt;
    dk_r     <= dk_nxt;
    out_sm_r <= out_sm_nxt;
    out_pk_r <= out_pk_nxt;
    out_dk_r <= out_dk_nxt;
  end

  // band stores: single shared index, one write per cycle
  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_r[idx_r] <= prev_wd;
    end
    if (peak_we) begin
      peak_r[idx_r] <= peak_wd;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_smoothed_level = out_sm_r;
  assign out_peak_level     = out_pk_r;
  assign out_decay_done     = out_dk_r;

endmodule

// ===== hw/rtl/blsph_div.sv =====
module blsph_div (
  input  logic                clk,
  input  logic                rst_n,
  input  blsph_pkg::div_req_t req,
  output blsph_pkg::div_rsp_t rsp
);
  import blsph_pkg::*;

  // restoring divider, one quotient bit a cycle; quotient shifts into dvd_r
  logic [RAW_W-1:0] dvd_r, dvd_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] dsr_r, dsr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [DIV_W:0]   trial;

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    trial    = {rem_r, dvd_r[RAW_W-1]};
    if (req.start) begin
      dvd_nxt = req.dividend;
      dsr_nxt = req.divisor;
      rem_nxt = '0;
      cnt_nxt = CNT_W'(RAW_W);
    end else if (cnt_r != '0) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = DIV_W'(trial - {1'b0, dsr_r});
        dvd_nxt = {dvd_r[RAW_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIV_W-1:0];
        dvd_nxt = {dvd_r[RAW_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

endmodule

// ===== hw/rtl/blsph_regs.sv =====
module blsph_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [blsph_pkg::ADDR_W-1:0] paddr,
  input  logic [blsph_pkg::DATA_W-1:0] pwdata,
  output logic [blsph_pkg::DATA_W-1:0] prdata,
  output logic                         pready,
  output blsph_pkg::cfg_t              cfg
);
  import blsph_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_FINE_MODE: cfg_nxt.fine_mode         = pwdata[0];
        REG_BAR_DIV:   cfg_nxt.bar_divisor       = pwdata[DIV_W-1:0];
        REG_FINE_DIV:  cfg_nxt.fine_divisor      = pwdata[DIV_W-1:0];
        REG_SMOOTH:    cfg_nxt.smoothing_percent = pwdata[PCT_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FINE_MODE: prdata = DATA_W'(cfg_r.fine_mode);
      REG_BAR_DIV:   prdata = DATA_W'(cfg_r.bar_divisor);
      REG_FINE_DIV:  prdata = DATA_W'(cfg_r.fine_divisor);
      REG_SMOOTH:    prdata = DATA_W'(cfg_r.smoothing_percent);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fine_mode         <= 1'b0;
      cfg_r.bar_divisor       <= DIV_W'(1);
      cfg_r.fine_divisor      <= DIV_W'(1);
      cfg_r.smoothing_percent <= PCT_W'(50);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/blsph_chk.sv =====
module blsph_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [blsph_pkg::LEVEL_W-1:0] out_smoothed_level,
  input logic [blsph_pkg::PEAK_W-1:0]  out_peak_level,
  input logic                          out_decay_done,
  input logic                          pready
);
  import blsph_pkg::*;

  // one item at a time: no transfer in back-to-back cycles
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_smoothed_level)
                                   && $stable(out_peak_level) && $stable(out_decay_done)))
    else $error("stalled result changed");

  a_decay_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_decay_done) |-> (out_smoothed_level == '0 && out_peak_level == '0))
    else $error("decay result carries a level or peak");

  a_peak_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_peak_level <= PEAK_W'(PEAK_CAP)))
    else $error("peak above bar height");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("pready dropped");

endmodule

bind band_level_smoother_peak_hold blsph_chk u_blsph_chk (.*);

// ===== tb/tb_band_level_smoother_peak_hold.sv =====
`timescale 1ns / 100ps

module tb_band_level_smoother_peak_hold;
  import blsph_pkg::*;

  // One result as the block reports it.
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [PEAK_W-1:0]  peak;
    logic               done;
  } bar_result_t;

  // A row of the directed plan is either an item transfer or a register write.
  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic               cmd;
    logic [BIDX_W-1:0]  band;
    logic [RAW_W-1:0]   raw;
    logic [1:0]         reg_idx;
    logic [DATA_W-1:0]  val;
    logic               typed;   // expectation written in the row itself
    bar_result_t        want;
  } plan_row_t;

  localparam int PLAN_LEN       = 30;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 40;
  localparam int LONG_HOLD      = 400;   // receiver back-pressure, in cycles
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 80;    // longer than one slow sample
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer

  // Directed plan. Rows flagged typed carry results that follow directly from
  // reset values, caps or a zero divisor; the rest go through the predictor.
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // fresh from reset: decay on empty peaks, silent band, full-scale band
    '{ROW_ITEM, CMD_DECAY,  4'd0,  24'd0,       REG_FINE_MODE, 32'd0, 1'b1,
      '{12'd0, 5'd0, 1'b1}},
    '{ROW_ITEM, CMD_SAMPLE, 4'd0,  24'd0,       REG_FINE_MODE, 32'd0, 1'b1,
      '{12'd0, 5'd0, 1'b0}},
    '{ROW_ITEM, CMD_SAMPLE, 4'd15, 24'hFFFFFF,  REG_FINE_MODE, 32'd0, 1'b1,
      '{12'd8, 5'd8, 1'b0}},
    '{ROW_ITEM, CMD_SAMPLE, 4'd15, 24'hFFFFFF,  REG_FINE_MODE, 32'd0, 1'b0, '0},
    '{ROW_ITEM, CMD_DECAY,  4'd7,  24'h123456,  REG_FINE_MODE, 32'd0, 1'b1,
      '{12'd0, 5'd0, 1'b1}},
    '{ROW_ITEM, CMD_SAMPLE, 4'd10, 24'd5,       REG_FINE_MODE, 32'd0, 1'b0, '0},
    // full weight on the new level, zero bar divisor saturates to the bar cap
    '{ROW_REG,  CMD_SAMPLE, 4'd0,  24'd0,       REG_SMOOTH,    32'd100, 1'b0, '0},
    '{ROW_REG,  CMD_SAMPLE, 4'd0,  24'd0,       REG_BAR_DIV,   32'd0, 1'b0, '0},
    '{ROW_ITEM, CMD_SAMPLE, 4'd3,  24'd0,       REG_FINE_MODE, 32'd0, 1'b1,
      '{12'd16, 5'd16, 1'b0}},
    '{ROW_REG,  CMD_SAMPLE, 4'd0,  24'd0,       REG_BAR_DIV,   32'd65535, 1'b0, '0},
    '{ROW_ITEM, CMD_SAMPLE, 4'd3,  24'hFFFFFF,  REG_FINE_MODE, 32'd0, 1'b0, '0},
    '{ROW_ITEM, CMD_SAMPLE, 4'd3,  24'h00FFFE,  REG_FINE_MODE, 32'd0, 1'b0, '0},
    // fine mode: zero divisor gives the fine cap, peak left alone
    '{ROW_REG,  CMD_SAMPLE, 4'd0,  24'd0,       REG_FINE_MODE, 32'd1, 1'b0, '0},
    '{ROW_REG,  CMD_SAMPLE, 4'd0,  24'd0,       REG_FINE_DIV,  32'd0, 1'b0, '0},
    '{ROW_ITEM, CMD_SAMPLE, 4'd5,  24'd5,       REG_FINE_MODE, 32'd0, 1'b1,
      '{12'd4080, 5'd0, 1'b0}},
    '{ROW_REG,  CMD_SAMPLE, 4'd0,  24'd0,       REG_FINE_DIV,  32'd65535, 1'b0, '0},
    '{ROW_ITEM, CMD_SAMPLE, 4'd5,  24'hFFFFFF,  REG_FINE_MODE, 32'd0, 1'b0, '0},
    // zero weight holds the old level; above 100 acts as 100
    '{ROW_REG,  CMD_SAMPLE, 4'd0,  24'd0,       REG_SMOOTH,    32'd0, 1'b0, '0},
    '{ROW_ITEM, CMD_SAMPLE, 4'd5,  24'hAAAAAA,  REG_FINE_MODE, 32'd0, 1'b0, '0},
    '{ROW_REG,  CMD_SAMPLE, 4'd0,  24'd0,       REG_SMOOTH,    32'd127, 1'b0, '0},
    '{ROW_ITEM, CMD_SAMPLE, 4'd15, 24'h555555,  REG_FINE_MODE, 32'd0, 1'b0, '0},
    '{ROW_ITEM, CMD_DECAY,  4'd9,  24'hFFFFFF,  REG_FINE_MODE, 32'd0, 1'b1,
      '{12'd0, 5'd0, 1'b1}},
    '{ROW_REG,  CMD_SAMPLE, 4'd0,  24'd0,       REG_FINE_DIV,  32'd1, 1'b0, '0},
    '{ROW_ITEM, CMD_SAMPLE, 4'd0,  24'hAAAAAA,  REG_FINE_MODE, 32'd0, 1'b0, '0},
    // back to bar mode: a large fine-mode level is smoothed as stored
    '{ROW_REG,  CMD_SAMPLE, 4'd0,  24'd0,       REG_FINE_MODE, 32'd0, 1'b0, '0},
    '{ROW_REG,  CMD_SAMPLE, 4'd0,  24'd0,       REG_BAR_DIV,   32'd3, 1'b0, '0},
    '{ROW_REG,  CMD_SAMPLE, 4'd0,  24'd0,       REG_SMOOTH,    32'd37, 1'b0, '0},
    '{ROW_ITEM, CMD_SAMPLE, 4'd0,  24'd30,      REG_FINE_MODE, 32'd0, 1'b0, '0},
    '{ROW_ITEM, CMD_SAMPLE, 4'd15, 24'hFFFFFF,  REG_FINE_MODE, 32'd0, 1'b0, '0},
    '{ROW_ITEM, CMD_SAMPLE, 4'd10, 24'h00002A,  REG_FINE_MODE, 32'd0, 1'b0, '0}
  };

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                in_cmd;
  logic [BIDX_W-1:0]   in_band_index;
  logic [RAW_W-1:0]    in_raw_level;
  logic                out_valid;
  logic                out_ready;
  logic [LEVEL_W-1:0]  out_smoothed_level;
  logic [PEAK_W-1:0]   out_peak_level;
  logic                out_decay_done;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // Expectation travelling with the item on offer; only typed rows use it.
  logic                item_typed;
  bar_result_t         item_want;

  // Predictor's copy of the registers and the per-band stores.
  logic                mode_fine;
  logic [DIV_W-1:0]    div_bar;
  logic [DIV_W-1:0]    div_fine;
  logic [PCT_W-1:0]    pct_new;
  logic [LEVEL_W-1:0]  level_mem [BAND_CNT];
  logic [PEAK_W-1:0]   peak_mem  [BAND_CNT];

  bar_result_t         pending_bars [$];   // results owed by the block, oldest first
  int                  errors;
  int                  quiet_cycles;
  bit                  idling;             // random gaps and stalls allowed
  bit                  long_hold_req;      // ask the receiver for one long hold-off

  band_level_smoother_peak_hold uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cmd             (in_cmd),
    .in_band_index      (in_band_index),
    .in_raw_level       (in_raw_level),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_smoothed_level (out_smoothed_level),
    .out_peak_level     (out_peak_level),
    .out_decay_done     (out_decay_done),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Advance the bar state by one item and return the result it should give.
  // Decay ticks walk every band from 0; fine-mode samples leave the peaks alone.
  function automatic bar_result_t advance_bars(input logic cmd,
                                               input logic [BIDX_W-1:0] band,
                                               input logic [RAW_W-1:0] raw);
    bar_result_t res;
    int unsigned cap, dv, lvl, wt, sm, pk;
    int          b;
    res = '0;
    if (cmd == CMD_DECAY) begin
      for (b = 0; b < BAND_CNT; b++)
        if (peak_mem[b] != '0) peak_mem[b] = peak_mem[b] - 1'b1;
      res.done = 1'b1;
      return res;
    end
    if (int'(band) >= BAND_CNT) return res;
    cap = mode_fine ? FINE_CAP : BAR_CAP;
    dv  = mode_fine ? div_fine : div_bar;
    if (dv == 0) lvl = cap;
    else begin
      lvl = raw / dv;
      if (lvl > cap) lvl = cap;
    end
    wt = (pct_new > PCT_FULL) ? PCT_FULL : pct_new;
    sm = (level_mem[band] * (PCT_FULL - wt) + lvl * wt) / PCT_FULL;
    if (sm > LEVEL_MAX) sm = LEVEL_MAX;
    level_mem[band] = sm[LEVEL_W-1:0];
    pk = peak_mem[band];
    if (!mode_fine && sm > pk) begin
      pk = (sm > PEAK_CAP) ? PEAK_CAP : sm;
      peak_mem[band] = pk[PEAK_W-1:0];
    end
    res.level = sm[LEVEL_W-1:0];
    res.peak  = pk[PEAK_W-1:0];
    return res;
  endfunction

  // Offer one item, optionally after a burst of idle cycles, and return at
  // the edge where the transfer happens. Valid stays high on return.
  task automatic send_item(input logic cmd, input logic [BIDX_W-1:0] band,
                           input logic [RAW_W-1:0] raw, input logic typed,
                           input bar_result_t want);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_band_index <= band;
    in_raw_level  <= raw;
    item_typed    <= typed;
    item_want     <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait until every owed result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_bars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write, then a read-back of the same register.
  task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] val);
    logic [DATA_W-1:0] kept;
    case (idx)
      REG_FINE_MODE: begin
        mode_fine = val[0];
        kept = {{(DATA_W-1){1'b0}}, val[0]};
      end
      REG_BAR_DIV: begin
        div_bar = val[DIV_W-1:0];
        kept = {{(DATA_W-DIV_W){1'b0}}, val[DIV_W-1:0]};
      end
      REG_FINE_DIV: begin
        div_fine = val[DIV_W-1:0];
        kept = {{(DATA_W-DIV_W){1'b0}}, val[DIV_W-1:0]};
      end
      default: begin
        pct_new = val[PCT_W-1:0];
        kept = {{(DATA_W-PCT_W){1'b0}}, val[PCT_W-1:0]};
      end
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // write lands here; go straight into the read setup
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== kept) begin
      errors++;
      $error("prdata at 0x%0h: expected 0x%0h, got 0x%0h", {idx, 2'b00}, kept, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: random ready/stall bursts, one long hold-off on request.
  initial begin : sink
    out_ready <= 1'b0;
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (idling && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Every input transfer advances the predictor; typed rows override its answer.
  always @(posedge clk) begin : take_item
    bar_result_t got;
    if (rst_n && in_valid && in_ready) begin
      got = advance_bars(in_cmd, in_band_index, in_raw_level);
      pending_bars.push_back(item_typed ? item_want : got);
    end
  end

  // Each result transfer is matched against the oldest expectation.
  always @(posedge clk) begin : check_result
    bar_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_bars.size() == 0) begin
        errors++;
        $error("unexpected result: smoothed_level %0d, peak_level %0d, decay_done %0b",
               out_smoothed_level, out_peak_level, out_decay_done);
      end else begin
        want = pending_bars.pop_front();
        if (out_smoothed_level !== want.level) begin
          errors++;
          $error("smoothed_level: expected %0d, got %0d", want.level, out_smoothed_level);
        end
        if (out_peak_level !== want.peak) begin
          errors++;
          $error("peak_level: expected %0d, got %0d", want.peak, out_peak_level);
        end
        if (out_decay_done !== want.done) begin
          errors++;
          $error("decay_done: expected %0b, got %0b", want.done, out_decay_done);
        end
      end
    end
  end

  // Watchdog: too long without any transfer on any port ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      quiet_cycles <= 0;
    else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_band_level_smoother_peak_hold failed");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : stimulus
    plan_row_t         row;
    logic              cmd;
    logic [BIDX_W-1:0] band;
    logic [RAW_W-1:0]  raw;
    logic              fine;
    logic [DIV_W-1:0]  dv_pick [2];
    logic [PCT_W-1:0]  pct_pick;
    int unsigned       dv;
    int unsigned       aim;
    longint unsigned   wide;

    errors        = 0;
    idling        = 1'b1;
    long_hold_req = 1'b0;
    // predictor starts from the reset values of the registers
    mode_fine = 1'b0;
    div_bar   = 1;
    div_fine  = 1;
    pct_new   = 50;
    for (int b = 0; b < BAND_CNT; b++) begin
      level_mem[b] = '0;
      peak_mem[b]  = '0;
    end
    in_valid      <= 1'b0;
    in_cmd        <= CMD_SAMPLE;
    in_band_index <= '0;
    in_raw_level  <= '0;
    item_typed    <= 1'b0;
    item_want     <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;

    while (!rst_n) @(posedge clk);

    // directed part
    for (int i = 0; i < PLAN_LEN; i++) begin
      row = PLAN[i];
      if (row.kind == ROW_REG) begin
        settle();
        reg_write(row.reg_idx, row.val);
      end else
        send_item(row.cmd, row.band, row.raw, row.typed, row.want);
    end

    // random phases, each with its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      fine = ph[0];
      for (int k = 0; k < 2; k++)
        case ($urandom_range(0, 9))
          0:       dv_pick[k] = '0;
          1:       dv_pick[k] = '1;
          2:       dv_pick[k] = DIV_W'(1);
          3:       dv_pick[k] = DIV_W'($urandom_range(1, 65535));
          default: dv_pick[k] = DIV_W'($urandom_range(1, 5000));
        endcase
      case ($urandom_range(0, 7))
        0:       pct_pick = '0;
        1:       pct_pick = PCT_W'(PCT_FULL);
        2:       pct_pick = PCT_W'($urandom_range(101, 127));
        default: pct_pick = PCT_W'($urandom_range(1, 99));
      endcase
      reg_write(REG_FINE_MODE, {{(DATA_W-1){1'b0}}, fine});
      reg_write(REG_BAR_DIV,   {{(DATA_W-DIV_W){1'b0}}, dv_pick[0]});
      reg_write(REG_FINE_DIV,  {{(DATA_W-DIV_W){1'b0}}, dv_pick[1]});
      reg_write(REG_SMOOTH,    {{(DATA_W-PCT_W){1'b0}}, pct_pick});
      // third phase: receiver holds off so the block backs up into in_ready
      if (ph == 2) long_hold_req = 1'b1;
      // last phase runs flat out on both sides
      if (ph == PHASES - 1) idling = 1'b0;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        cmd  = ($urandom_range(0, 7) == 0) ? CMD_DECAY : CMD_SAMPLE;
        band = BIDX_W'($urandom_range(0, BAND_CNT - 1));
        dv   = mode_fine ? div_fine : div_bar;
        case ($urandom_range(0, 7))
          0:       raw = '0;
          1:       raw = '1;
          2, 3:    raw = RAW_W'($urandom);
          default: begin
            // aim near the clamp so smoothing and peaks see useful levels
            aim  = $urandom_range(0, mode_fine ? FINE_CAP + 100 : BAR_CAP + 4);
            wide = longint'(aim) * dv + ((dv > 0) ? $urandom_range(0, dv - 1) : 0);
            raw  = (wide > 64'hFFFFFF) ? '1 : wide[RAW_W-1:0];
          end
        endcase
        send_item(cmd, band, raw, 1'b0, '0);
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending_bars.size() == 0)
      $display("tb_band_level_smoother_peak_hold passed");
    else
      $display("tb_band_level_smoother_peak_hold failed");
    $finish;
  end

endmodule
